// ===== hdl/fcsg_pkg.sv =====
// Package for the four channel sound generator: opcodes, register offsets,
// configuration indexes and small constant tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcsg_pkg;
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_FRAME = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   localparam int unsigned CFG_SAMPLE_DIVIDER = 0;
   localparam logic [6:0] DIVIDER_RESET = 7'd95;
   localparam logic [23:0] SQ_LIMIT = 24'd8188;
   localparam logic [15:0] NOISE_SEED = 16'h7fff;

   localparam logic [5:0] A_NR11 = 6'h11, A_NR12 = 6'h12, A_NR13 = 6'h13,
      A_NR14 = 6'h14, A_NR21 = 6'h16, A_NR22 = 6'h17, A_NR23 = 6'h18,
      A_NR24 = 6'h19, A_NR30 = 6'h1a, A_NR31 = 6'h1b, A_NR32 = 6'h1c,
      A_NR33 = 6'h1d, A_NR34 = 6'h1e, A_NR41 = 6'h20, A_NR42 = 6'h21,
      A_NR43 = 6'h22, A_NR44 = 6'h23, A_NR51 = 6'h25, A_NR52 = 6'h26;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] ph);
      logic [7:0] pat;
      begin
         unique case (sel)
            2'd0: pat = 8'h80;
            2'd1: pat = 8'h81;
            2'd2: pat = 8'he1;
            default: pat = 8'h7e;
         endcase
         duty_bit = pat[ph];
      end
   endfunction

   function automatic logic [3:0] wave_out(input logic [3:0] nib, input logic [1:0] sel);
      begin
         unique case (sel)
            2'd0: wave_out = 4'd0;
            2'd1: wave_out = nib;
            2'd2: wave_out = nib >> 1;
            default: wave_out = nib >> 2;
         endcase
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/four_channel_sound_generator.sv =====
// Four channel sound generator: top level with register file, channel
// state, mixer and output register. Depends on fcsg_pkg.
//
// Usage. Items arrive on the req_ channel as beats carrying an opcode,
// a register offset and a data byte: opcode 0 writes a register, 1 is a
// sample tick and 2 a frame sequencer tick. Every item is consumed by
// the register/channel logic, so one beat can be accepted in every cycle
// but for a held-off sample tick (see below). A sample tick that completes
// a divider period loads a mixed level into the output register, which
// appears on rsp_ in the cycle after the tick is accepted.
// The output register acts as the skid stage: while a level waits on a
// stalled receiver, further write and frame beats still flow; only a
// sample tick that would emit a new level is held off until the waiting
// level has been taken, or is taken in the same cycle.
// The csr_ port holds the sample divider at offset 0 (reset 95).
// Reset is synchronous and active high: all registers zero with power
// off, channels inactive, the noise register seeded to all ones in its
// low fifteen bits, and no level pending.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_sound_generator
   import fcsg_pkg::*;
#(
   parameter int NOISE_COUNTER_WIDTH = 24
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_opcode,
   input wire logic [5:0] req_reg_addr,
   input wire logic [7:0] req_write_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [6:0] rsp_sample_level,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int NW = NOISE_COUNTER_WIDTH;

   logic [7:0] regs_ff [48];
   logic [3:0] act_ff, act_in;
   logic [23:0] pc_ff [3], pc_in [3], rl_ff [3], rl_in [3];
   logic [NW-1:0] npc_ff, npc_in, nrl_ff, nrl_in;
   logic [2:0] ph0_ff, ph0_in, ph1_ff, ph1_in;
   logic [4:0] ph2_ff, ph2_in;
   logic [9:0] len_ff [4], len_in [4];
   logic [3:0] vol_ff [4], vol_in [4];
   logic [4:0] env_ff [4], env_in [4];
   logic [15:0] ns_ff, ns_in;
   logic [6:0] cnt_ff, cnt_in, div_ff;
   logic rv_ff, rv_in;
   logic signed [6:0] lvl_ff, lvl_in;
   logic wr_en;
   logic [5:0] wr_idx;

   function automatic logic [7:0] rd(input logic [5:0] a);
      logic [5:0] i;
      begin
         i = a - 6'd16;
         rd = (i < 6'd48) ? regs_ff[i] : 8'd0;
      end
   endfunction

   // Control registers whose individual fields are picked apart below.
   logic [7:0] nr11, nr12, nr21, nr22, nr30, nr31, nr32, nr41, nr42, nr43, nr52;
   assign nr11 = regs_ff[A_NR11 - 6'd16];
   assign nr12 = regs_ff[A_NR12 - 6'd16];
   assign nr21 = regs_ff[A_NR21 - 6'd16];
   assign nr22 = regs_ff[A_NR22 - 6'd16];
   assign nr30 = regs_ff[A_NR30 - 6'd16];
   assign nr31 = regs_ff[A_NR31 - 6'd16];
   assign nr32 = regs_ff[A_NR32 - 6'd16];
   assign nr41 = regs_ff[A_NR41 - 6'd16];
   assign nr42 = regs_ff[A_NR42 - 6'd16];
   assign nr43 = regs_ff[A_NR43 - 6'd16];
   assign nr52 = regs_ff[A_NR52 - 6'd16];

   // An emitting tick is only blocked while a level is still waiting.
   logic emit_next;
   assign emit_next = ({1'b0, cnt_ff} + 8'd1) >= {1'b0, div_ff};
   assign req_ready = !(req_opcode == OP_SAMPLE && emit_next && rv_ff && !rsp_ready);
   wire accept = req_valid && req_ready;
   wire power = nr52[7];

   logic [7:0] mix;
   logic [5:0] total;
   logic [10:0] p;
   logic [NW-1:0] np;
   logic [8:0] npbase;
   logic [3:0] nib;
   logic fb;
   logic [4:0] wph;
   always_comb begin
      act_in = act_ff;
      pc_in = pc_ff; rl_in = rl_ff; npc_in = npc_ff; nrl_in = nrl_ff;
      ph0_in = ph0_ff; ph1_in = ph1_ff; ph2_in = ph2_ff;
      len_in = len_ff; vol_in = vol_ff; env_in = env_ff;
      ns_in = ns_ff; cnt_in = cnt_ff;
      rv_in = rv_ff && !rsp_ready; lvl_in = lvl_ff;
      wr_en = 1'b0; wr_idx = req_reg_addr - 6'd16;
      mix = rd(A_NR51); total = '0; p = '0; np = '0; npbase = '0;
      nib = '0; fb = 1'b0; wph = '0;
      if (accept) begin
         unique case (req_opcode)
            OP_WRITE: begin
               if (req_reg_addr >= 6'd16 && (req_reg_addr == A_NR52 || power)) begin
                  wr_en = 1'b1;
               end
               if (req_reg_addr >= 6'd16 && req_reg_addr != A_NR52 && power) begin
                  unique case (req_reg_addr)
                     A_NR12: if ((req_write_data & 8'hf8) == 0) act_in[0] = 1'b0;
                     A_NR22: if ((req_write_data & 8'hf8) == 0) act_in[1] = 1'b0;
                     A_NR30: if (!req_write_data[7]) act_in[2] = 1'b0;
                     A_NR42: if ((req_write_data & 8'hf8) == 0) act_in[3] = 1'b0;
                     A_NR14: if (req_write_data[7] && (rd(A_NR12) & 8'hf8) != 0) begin
                        p = {req_write_data[2:0], rd(A_NR13)};
                        act_in[0] = 1'b1;
                        len_in[0] = {3'd0, nr11[5:0], 1'b0};
                        rl_in[0] = {11'd0, p, 2'd0}; pc_in[0] = {11'd0, p, 2'd0};
                        vol_in[0] = nr12[7:4]; env_in[0] = '0;
                     end
                     A_NR24: if (req_write_data[7] && (rd(A_NR22) & 8'hf8) != 0) begin
                        p = {req_write_data[2:0], rd(A_NR23)};
                        act_in[1] = 1'b1;
                        len_in[1] = {3'd0, nr21[5:0], 1'b0};
                        rl_in[1] = {11'd0, p, 2'd0}; pc_in[1] = {11'd0, p, 2'd0};
                        vol_in[1] = nr22[7:4]; env_in[1] = '0;
                     end
                     A_NR34: if (req_write_data[7] && nr30[7]) begin
                        p = {req_write_data[2:0], rd(A_NR33)};
                        act_in[2] = 1'b1; ph2_in = '0;
                        len_in[2] = {1'b0, nr31, 1'b0};
                        rl_in[2] = {11'd0, p, 2'd0}; pc_in[2] = {11'd0, p, 2'd0};
                     end
                     A_NR44: if (req_write_data[7] && (rd(A_NR42) & 8'hf8) != 0) begin
                        npbase = (nr43[2:0] != 3'd0) ?
                           {2'd0, nr43[2:0], 4'd0} : 9'd8;
                        np = NW'({npbase, 1'b0}) << nr43[7:4];
                        act_in[3] = 1'b1;
                        len_in[3] = {3'd0, nr41[5:0], 1'b0};
                        nrl_in = np; npc_in = np;
                        vol_in[3] = nr42[7:4]; env_in[3] = '0;
                        ns_in = NOISE_SEED;
                     end
                     default: ;
                  endcase
               end
            end
            OP_FRAME: begin
               for (int c = 0; c < 4; c++) begin
                  logic [7:0] lr, er;
                  lr = (c == 0) ? rd(A_NR14) : (c == 1) ? rd(A_NR24) :
                       (c == 2) ? rd(A_NR34) : rd(A_NR44);
                  er = (c == 0) ? rd(A_NR12) : (c == 1) ? rd(A_NR22) : rd(A_NR42);
                  if (act_ff[c]) begin
                     if (lr[6]) begin
                        len_in[c] = len_ff[c] + 10'd1;
                        if ((c == 2) ? (len_in[c] == 10'd512 || len_in[c] > 10'd512)
                                     : (len_in[c] >= 10'd128))
                           act_in[c] = 1'b0;
                     end
                     if (c != 2) begin
                        env_in[c] = env_ff[c] + 5'd1;
                        if (env_in[c] >= {er[2:0], 2'd0}) begin
                           env_in[c] = '0;
                           if (er[3]) begin
                              if (vol_ff[c] != 4'd15) vol_in[c] = vol_ff[c] + 4'd1;
                           end else if (vol_ff[c] != 4'd0) begin
                              vol_in[c] = vol_ff[c] - 4'd1;
                           end
                        end
                     end
                  end
               end
            end
            OP_SAMPLE: begin
               if (power) begin
                  if (act_ff[0]) begin
                     pc_in[0] = pc_ff[0] + 24'd1;
                     if (pc_in[0] > SQ_LIMIT) begin
                        ph0_in = ph0_ff + 3'd1; pc_in[0] = rl_ff[0];
                     end
                     if (mix[0] | mix[4])
                        total = total + (duty_bit(nr11[7:6], ph0_in) ?
                           {2'd0, vol_ff[0]} : 6'd0);
                  end
                  if (act_ff[1]) begin
                     pc_in[1] = pc_ff[1] + 24'd1;
                     if (pc_in[1] > SQ_LIMIT) begin
                        ph1_in = ph1_ff + 3'd1; pc_in[1] = rl_ff[1];
                     end
                     if (mix[1] | mix[5])
                        total = total + (duty_bit(nr21[7:6], ph1_in) ?
                           {2'd0, vol_ff[1]} : 6'd0);
                  end
                  if (act_ff[2]) begin
                     pc_in[2] = pc_ff[2] + 24'd1;
                     if (pc_in[2] > SQ_LIMIT) begin
                        ph2_in = ph2_ff + 5'd1; pc_in[2] = rl_ff[2];
                     end
                     wph = ph2_in;
                     nib = wph[0] ? regs_ff[6'd32 + {2'd0, wph[4:1]}][3:0]
                                  : regs_ff[6'd32 + {2'd0, wph[4:1]}][7:4];
                     if (mix[2] | mix[6])
                        total = total + {2'd0, wave_out(nib, nr32[6:5])};
                  end
                  if (act_ff[3]) begin
                     npc_in = npc_ff - NW'(1);
                     if (npc_in == '0) begin
                        fb = ~(ns_ff[0] ^ ns_ff[1]);
                        ns_in = {fb, ns_ff[15:1]};
                        if (nr43[2]) ns_in[6] = fb;
                        npc_in = nrl_ff;
                     end
                     if ((mix[3] | mix[7]) && ns_in[0])
                        total = total + {2'd0, vol_ff[3]};
                  end
               end
               cnt_in = cnt_ff + 7'd1;
               if (emit_next) begin
                  cnt_in = '0; rv_in = 1'b1;
                  lvl_in = power ? 7'({total, 1'b0} - 7'd60) : 7'sd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 48; i++) regs_ff[i] <= '0;
         act_ff <= '0;
         for (int i = 0; i < 3; i++) begin pc_ff[i] <= '0; rl_ff[i] <= '0; end
         for (int i = 0; i < 4; i++) begin
            len_ff[i] <= '0; vol_ff[i] <= '0; env_ff[i] <= '0;
         end
         npc_ff <= '0; nrl_ff <= '0;
         ph0_ff <= '0; ph1_ff <= '0; ph2_ff <= '0;
         ns_ff <= NOISE_SEED; cnt_ff <= '0; div_ff <= DIVIDER_RESET;
         rv_ff <= 1'b0; lvl_ff <= '0;
      end else begin
         if (wr_en) regs_ff[wr_idx] <= req_write_data;
         act_ff <= act_in; pc_ff <= pc_in; rl_ff <= rl_in;
         npc_ff <= npc_in; nrl_ff <= nrl_in;
         ph0_ff <= ph0_in; ph1_ff <= ph1_in; ph2_ff <= ph2_in;
         len_ff <= len_in; vol_ff <= vol_in; env_ff <= env_in;
         ns_ff <= ns_in; cnt_ff <= cnt_in;
         rv_ff <= rv_in; lvl_ff <= lvl_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'(CFG_SAMPLE_DIVIDER))
            div_ff <= csr_pwdata[6:0];
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_sample_level = lvl_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'(CFG_SAMPLE_DIVIDER)) ? {25'd0, div_ff} : 32'd0;

   // A waiting level must hold until the receiver takes it.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_level))
      else $error("level changed while stalled");
   // The level register only fills from an accepted sample tick.
   a_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_opcode == OP_SAMPLE) |=> !rsp_valid)
      else $error("level without sample tick");
   // While power is off every emitted level is silence.
   a_off: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_SAMPLE && !power && emit_next
      |=> rsp_sample_level == 7'sd0)
      else $error("level while powered off");
endmodule
`default_nettype wire

// ===== tb/tb_four_channel_sound_generator.sv =====
// Self-checking testbench for the four channel sound generator: a directed
// pass, random passes under varying back-pressure and a long receiver stall.
// Depends on fcsg_pkg and four_channel_sound_generator.
`timescale 1ns / 1ps
module tb_four_channel_sound_generator;
   import fcsg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [5:0] req_reg_addr;
   logic [7:0] req_write_data;
   logic rsp_valid, rsp_ready;
   logic signed [6:0] rsp_sample_level;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   four_channel_sound_generator dut (.*);

   // Shadow copy of the generator state, advanced once per accepted beat.
   logic [7:0] snd_regs [0:47];
   bit ch_on [4];
   logic [23:0] per_cnt [4];
   logic [23:0] per_reload [4];
   logic [4:0] step_pos [3];
   logic [9:0] len_cnt [4];
   logic [3:0] ch_vol [4];
   logic [4:0] env_cnt [4];
   logic [15:0] lfsr;
   logic [6:0] tick_cnt;
   logic [6:0] divider_now;
   logic [7:0] duty_pat [4] = '{8'h80, 8'h81, 8'he1, 8'h7e};

   logic signed [6:0] level_q [$];
   int errors = 0;
   int beats_sent = 0;
   int levels_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is bounded so that a hung handshake cannot stall it forever.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels outstanding", cycles,
                     level_q.size());
            $display("FAIL four_channel_sound_generator");
            $finish;
         end
      end
   end

   function automatic logic [7:0] rd(input int a);
      return snd_regs[(a - 16) & 63];
   endfunction

   task automatic model_reset();
      foreach (snd_regs[i]) snd_regs[i] = 8'h00;
      for (int c = 0; c < 4; c++) begin
         ch_on[c] = 1'b0;
         per_cnt[c] = '0;
         per_reload[c] = '0;
         len_cnt[c] = '0;
         ch_vol[c] = '0;
         env_cnt[c] = '0;
         if (c < 3) step_pos[c] = '0;
      end
      lfsr = 16'h7fff;
      tick_cnt = '0;
      divider_now = DIVIDER_RESET;
   endtask

   task automatic square_trigger(input int c, input int base);
      logic [10:0] p;
      ch_on[c] = 1'b1;
      len_cnt[c] = (rd(base + 1) & 8'h3f) * 2;
      p = {rd(base + 4) & 8'h07, rd(base + 3)};
      per_reload[c] = p * 4;
      per_cnt[c] = p * 4;
      ch_vol[c] = rd(base + 2) >> 4;
      env_cnt[c] = '0;
   endtask

   task automatic apply_write(input logic [5:0] a, input logic [7:0] v);
      longint unsigned p;
      logic [7:0] r;
      logic [10:0] wp;
      if (a < 6'h10) return;
      if (a == A_NR52) begin
         snd_regs[a - 16] = v;
         return;
      end
      r = rd(A_NR52);
      if (!r[7]) return;
      snd_regs[a - 16] = v;
      case (a)
         A_NR12: if ((v & 8'hf8) == 0) ch_on[0] = 1'b0;
         A_NR22: if ((v & 8'hf8) == 0) ch_on[1] = 1'b0;
         A_NR30: if (!v[7]) ch_on[2] = 1'b0;
         A_NR42: if ((v & 8'hf8) == 0) ch_on[3] = 1'b0;
         A_NR14: if (v[7] && (rd(A_NR12) & 8'hf8) != 0) square_trigger(0, 16);
         A_NR24: if (v[7] && (rd(A_NR22) & 8'hf8) != 0) square_trigger(1, 21);
         A_NR34: begin
            if (v[7] && snd_regs[A_NR30 - 16][7]) begin
               wp = {rd(A_NR34) & 8'h07, rd(A_NR33)};
               ch_on[2] = 1'b1;
               step_pos[2] = '0;
               len_cnt[2] = rd(A_NR31) * 2;
               per_reload[2] = wp * 4;
               per_cnt[2] = wp * 4;
            end
         end
         A_NR44: begin
            if (v[7] && (rd(A_NR42) & 8'hf8) != 0) begin
               r = rd(A_NR43);
               p = (r[2:0] != 0) ? r[2:0] * 16 : 8;
               p = (p << (r[7:4] + 1)) & 64'hff_ffff;
               ch_on[3] = 1'b1;
               len_cnt[3] = (rd(A_NR41) & 8'h3f) * 2;
               per_reload[3] = p;
               per_cnt[3] = p;
               ch_vol[3] = rd(A_NR42) >> 4;
               env_cnt[3] = '0;
               lfsr = 16'h7fff;
            end
         end
         default: ;
      endcase
   endtask

   task automatic length_step(input int c, input int ctl, input int lim);
      if (snd_regs[ctl - 16][6]) begin
         len_cnt[c] = len_cnt[c] + 1;
         if (len_cnt[c] >= lim) ch_on[c] = 1'b0;
      end
   endtask

   task automatic envelope_step(input int c, input int env);
      logic [7:0] r;
      r = rd(env);
      env_cnt[c] = env_cnt[c] + 1;
      if (env_cnt[c] >= r[2:0] * 4) begin
         env_cnt[c] = '0;
         if (r[3]) begin
            if (ch_vol[c] < 15) ch_vol[c]++;
         end else if (ch_vol[c] != 0) ch_vol[c]--;
      end
   endtask

   function automatic int square_out(input int c, input int duty_addr);
      per_cnt[c] = per_cnt[c] + 1;
      if (per_cnt[c] > SQ_LIMIT) begin
         step_pos[c] = (step_pos[c] + 1) & 5'd7;
         per_cnt[c] = per_reload[c];
      end
      return duty_pat[rd(duty_addr) >> 6][step_pos[c][2:0]] ? ch_vol[c] : 0;
   endfunction

   // Advances the shadow state by one beat; an emitting sample tick queues
   // the level that the block must produce.
   task automatic advance_model(input opcode_type op, input logic [5:0] a,
                                input logic [7:0] d);
      int total;
      int s;
      logic [7:0] mix;
      logic [4:0] ph;
      logic [3:0] nib;
      logic fb;
      total = 0;
      case (op)
         OP_WRITE: apply_write(a, d);
         OP_FRAME: begin
            if (ch_on[0]) begin length_step(0, A_NR14, 128); envelope_step(0, A_NR12); end
            if (ch_on[1]) begin length_step(1, A_NR24, 128); envelope_step(1, A_NR22); end
            if (ch_on[2]) length_step(2, A_NR34, 512);
            if (ch_on[3]) begin length_step(3, A_NR44, 128); envelope_step(3, A_NR42); end
         end
         OP_SAMPLE: begin
            if (snd_regs[A_NR52 - 16][7]) begin
               mix = rd(A_NR51);
               if (ch_on[0]) begin
                  s = square_out(0, A_NR11);
                  if (mix & 8'h11) total += s;
               end
               if (ch_on[1]) begin
                  s = square_out(1, A_NR21);
                  if (mix & 8'h22) total += s;
               end
               if (ch_on[2]) begin
                  per_cnt[2] = per_cnt[2] + 1;
                  if (per_cnt[2] > SQ_LIMIT) begin
                     step_pos[2] = step_pos[2] + 1;
                     per_cnt[2] = per_reload[2];
                  end
                  ph = step_pos[2];
                  nib = ph[0] ? snd_regs[32 + ph[4:1]][3:0] : snd_regs[32 + ph[4:1]][7:4];
                  if (mix & 8'h44) begin
                     case (snd_regs[A_NR32 - 16][6:5])
                        2'd0: total += 0;
                        2'd1: total += nib;
                        2'd2: total += nib >> 1;
                        default: total += nib >> 2;
                     endcase
                  end
               end
               if (ch_on[3]) begin
                  per_cnt[3] = per_cnt[3] - 1;
                  if (per_cnt[3] == 0) begin
                     fb = ~(lfsr[0] ^ lfsr[1]);
                     lfsr = {fb, lfsr[15:1]};
                     if (snd_regs[A_NR43 - 16][2]) lfsr[6] = fb;
                     per_cnt[3] = per_reload[3];
                  end
                  if ((mix & 8'h88) && lfsr[0]) total += ch_vol[3];
               end
               s = total * 2 - 60;
            end else s = 0;
            tick_cnt = tick_cnt + 1;
            if (tick_cnt >= divider_now) begin
               tick_cnt = '0;
               level_q.push_back(s[6:0]);
            end
         end
         default: ;
      endcase
   endtask

   // One beat on the request side; valid is left high for the next call.
   task automatic send_item(input opcode_type op, input logic [5:0] a,
                            input logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_reg_addr <= a;
      req_write_data <= d;
      do @(posedge clock); while (!req_ready);
      advance_model(op, a, d);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wr(input logic [5:0] a, input logic [7:0] d);
      send_item(OP_WRITE, a, d);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (level_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Divider write followed by a read-back, both with the block idle.
   task automatic set_divider(input logic [6:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(CFG_SAMPLE_DIVIDER * 4);
      csr_pwdata <= {25'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      divider_now = v;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {25'd0, v}) begin
         $display("%0t divider read-back: expected %0d, got %0d", $time, v, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            levels_seen++;
            if (level_q.size() == 0) begin
               $display("%0t unexpected level: expected none, got %0d", $time,
                        rsp_sample_level);
               errors++;
            end else if (rsp_sample_level !== level_q[0]) begin
               $display("%0t sample_level: expected %0d, got %0d", $time, level_q[0],
                        rsp_sample_level);
               errors++;
               void'(level_q.pop_front());
            end else void'(level_q.pop_front());
         end
      end
   end

   // Power is off after reset, so the default divider yields one zero level.
   task automatic test_reset_defaults();
      repeat (DIVIDER_RESET) send_item(OP_SAMPLE, 6'h00, 8'h00);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_directed();
      set_divider(7'd1);
      send_item(OP_SAMPLE, 6'h3f, 8'hff);
      wr(A_NR12, 8'hf8);           // ignored while power is off
      wr(6'h05, 8'hff);            // below the register window
      send_item(OP_NONE, 6'h2a, 8'h55);
      wr(A_NR52, 8'h80);
      wr(A_NR51, 8'hff);
      wr(A_NR11, 8'hc0); wr(A_NR12, 8'hf8); wr(A_NR13, 8'hff); wr(A_NR14, 8'hc7);
      wr(A_NR21, 8'h3f); wr(A_NR22, 8'hf0); wr(A_NR23, 8'hff); wr(A_NR24, 8'h87);
      wr(6'h30, 8'hf0); wr(6'h31, 8'h5a);
      wr(A_NR30, 8'h80); wr(A_NR32, 8'h20); wr(A_NR33, 8'hff); wr(A_NR34, 8'hc7);
      wr(A_NR42, 8'hf0); wr(A_NR43, 8'h04); wr(A_NR44, 8'hc0);
      repeat (4) send_item(OP_SAMPLE, 6'h00, 8'h00);
      send_item(OP_FRAME, 6'h00, 8'h00);
      wr(A_NR12, 8'h00);           // silences the first square channel
      send_item(OP_SAMPLE, 6'h00, 8'h00);
      wr(A_NR52, 8'h00);
      send_item(OP_SAMPLE, 6'h00, 8'h00);
      stop_sending();
      wait_drained();
   endtask

   task automatic retrigger(input int c);
      case (c)
         0: begin
            wr(A_NR11, $urandom); wr(A_NR12, $urandom | 8'h10);
            wr(A_NR13, $urandom | 8'hf0); wr(A_NR14, $urandom | 8'h87);
         end
         1: begin
            wr(A_NR21, $urandom); wr(A_NR22, $urandom | 8'h10);
            wr(A_NR23, $urandom | 8'hf0); wr(A_NR24, $urandom | 8'h87);
         end
         2: begin
            wr(6'h30 + $urandom_range(15), $urandom); wr(A_NR30, 8'h80);
            wr(A_NR31, $urandom); wr(A_NR32, $urandom);
            wr(A_NR33, $urandom | 8'hf0); wr(A_NR34, $urandom | 8'h87);
         end
         default: begin
            wr(A_NR41, $urandom); wr(A_NR42, $urandom | 8'h10);
            wr(A_NR43, $urandom & 8'h3f); wr(A_NR44, $urandom | 8'h80);
         end
      endcase
   endtask

   task automatic random_item();
      int r;
      logic [5:0] a;
      logic [7:0] d;
      r = $urandom_range(99);
      d = $urandom;
      a = $urandom_range(16, 63);
      if (r < 48) send_item(OP_SAMPLE, $urandom, $urandom);
      else if (r < 58) send_item(OP_FRAME, $urandom, $urandom);
      else if (r < 60) send_item(OP_NONE, $urandom, $urandom);
      else if (r < 62) wr($urandom_range(15), d);
      else if (r < 64) wr(A_NR52, ($urandom_range(3) != 0) ? (d | 8'h80) : d);
      else if (r < 72) retrigger($urandom_range(3));
      else begin
         if ((a == A_NR14 || a == A_NR24 || a == A_NR34 || a == A_NR44)
             && $urandom_range(3) != 0) d = d | 8'h87;
         if ((a == A_NR13 || a == A_NR23 || a == A_NR33) && $urandom_range(3) != 0)
            d = d | 8'hf0;
         wr(a, d);
      end
   endtask

   task automatic test_random(input int n, input int s_idle, input int r_idle,
                              input logic [6:0] div);
      set_divider(div);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      wr(A_NR52, 8'h80);
      wr(A_NR51, 8'hff);
      for (int c = 0; c < 4; c++) retrigger(c);
      repeat (n) random_item();
      stop_sending();
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   // The receiver stops for a long stretch while ticks keep coming, so the
   // pending level blocks the input until the stall lifts.
   task automatic test_backpressure();
      set_divider(7'd1);
      hold_cycles = 300;
      wr(A_NR52, 8'h80);
      retrigger(0);
      repeat (60) send_item(OP_SAMPLE, 6'h00, 8'h00);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_divider_extremes();
      set_divider(7'd127);
      repeat (130) send_item(OP_SAMPLE, $urandom, $urandom);
      stop_sending();
      wait_drained();
      set_divider(7'd0);
      repeat (12) random_item();
      stop_sending();
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_NONE;
      req_reg_addr = '0;
      req_write_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      model_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed();
      test_random(100, 14, 80, 7'd2);
      test_random(100, 80, 14, 7'd1);
      test_random(100, 0, 0, 7'($urandom_range(1, 6)));
      test_backpressure();
      test_divider_extremes();

      $display("Covered %0d request beats and %0d output levels over all opcodes,",
               beats_sent, levels_seen);
      $display("four channels, power toggling, divider 0 to 127 and a long stall.");
      if (errors == 0 && level_q.size() == 0) begin
         $display("PASS four_channel_sound_generator");
      end else begin
         $display("%0d mismatches, %0d levels never seen", errors, level_q.size());
         $display("FAIL four_channel_sound_generator");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/fcsg_pkg.sv
hdl/four_channel_sound_generator.sv
tb/tb_four_channel_sound_generator.sv
